// ===== rtl/core/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types, codes and reset values of the button click / long-press unit.
// ----------------------------------------------------------------------------
package bcl_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CMP_W      = 33;

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_PRESSED      = 3'd1,
		EV_LONG_FIRST   = 3'd2,
		EV_LONG_REPEAT  = 3'd3,
		EV_LONG_FINISH  = 3'd4,
		EV_RELEASED     = 3'd5,
		EV_CLICK_FINISH = 3'd6
	} event_t;

	// register indexes, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_ACTIVE_LOW     = 3'd0,
		REG_DEBOUNCE_TIME  = 3'd1,
		REG_LONG_PRESS_MS  = 3'd2,
		REG_REPEAT_MS      = 3'd3,
		REG_MULTI_CLICK_MS = 3'd4
	} reg_idx_t;

	localparam logic        RST_ACTIVE_LOW     = 1'b1;
	localparam logic [7:0]  RST_DEBOUNCE_TIME  = 8'd20;
	localparam logic [15:0] RST_LONG_PRESS_MS  = 16'd1000;
	localparam logic [15:0] RST_REPEAT_MS      = 16'd500;
	localparam logic [15:0] RST_MULTI_CLICK_MS = 16'd400;

	typedef struct packed {
		logic        active_low;
		logic [7:0]  debounce_time;
		logic [15:0] long_press_ms;
		logic [15:0] repeat_ms;
		logic [15:0] multi_click_ms;
	} cfg_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  click_count;
		logic [15:0] held_ms;
		logic        is_pressed;
	} res_t;

	// timer plus poll interval, saturating at the all-ones value
	function automatic timer_t timer_add(input timer_t t, input logic [7:0] d);
		logic [TIMER_BITS:0] s;
		s = {1'b0, t} + (TIMER_BITS+1)'(d);
		return s[TIMER_BITS] ? '1 : s[TIMER_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/bcl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcl_cfg_regs
// APB register file holding the thresholds and the pressed polarity.
// ----------------------------------------------------------------------------
module bcl_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output bcl_pkg::cfg_t cfg
);
	import bcl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low     <= RST_ACTIVE_LOW;
			cfg_q.debounce_time  <= RST_DEBOUNCE_TIME;
			cfg_q.long_press_ms  <= RST_LONG_PRESS_MS;
			cfg_q.repeat_ms      <= RST_REPEAT_MS;
			cfg_q.multi_click_ms <= RST_MULTI_CLICK_MS;
		end else if (wr_en) begin
			case (idx)
				REG_ACTIVE_LOW:     cfg_q.active_low     <= pwdata[0];
				REG_DEBOUNCE_TIME:  cfg_q.debounce_time  <= pwdata[7:0];
				REG_LONG_PRESS_MS:  cfg_q.long_press_ms  <= pwdata[15:0];
				REG_REPEAT_MS:      cfg_q.repeat_ms      <= pwdata[15:0];
				REG_MULTI_CLICK_MS: cfg_q.multi_click_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ACTIVE_LOW:     prdata = 32'(cfg_q.active_low);
			REG_DEBOUNCE_TIME:  prdata = 32'(cfg_q.debounce_time);
			REG_LONG_PRESS_MS:  prdata = 32'(cfg_q.long_press_ms);
			REG_REPEAT_MS:      prdata = 32'(cfg_q.repeat_ms);
			REG_MULTI_CLICK_MS: prdata = 32'(cfg_q.multi_click_ms);
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/bcl_step.sv =====
// ----------------------------------------------------------------------------
// bcl_step
// Button state: timers, debounce, click counter and long-press tracking.
// ----------------------------------------------------------------------------
module bcl_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          pin_level,
	input  logic [7:0]    elapsed_ms,
	input  bcl_pkg::cfg_t cfg,
	output bcl_pkg::res_t res
);
	import bcl_pkg::*;

	logic   last_level_q;
	timer_t since_press_q;
	timer_t since_repeat_q;
	logic   press_accepted_q;
	logic   long_active_q;
	logic [7:0] clicks_q;
	timer_t hold_time_q;

	logic   pressed_level, now_p, before_p;
	timer_t sp, sr;
	logic   deb_ok, long_ok, rep_ok, multi_ok;

	timer_t     sp_d, sr_d, hold_d;
	logic       acc_d, long_d;
	logic [7:0] clicks_d;
	event_t     ev_d;

	assign pressed_level = ~cfg.active_low;
	assign now_p         = (pin_level == pressed_level);
	assign before_p      = (last_level_q == pressed_level);
	assign sp            = timer_add(since_press_q, elapsed_ms);
	assign sr            = timer_add(since_repeat_q, elapsed_ms);
	assign deb_ok        = CMP_W'(sp) >= CMP_W'(cfg.debounce_time);
	assign long_ok       = CMP_W'(sp) >= CMP_W'(cfg.long_press_ms);
	assign rep_ok        = CMP_W'(sr) >= CMP_W'(cfg.repeat_ms);
	assign multi_ok      = CMP_W'(sp) >= CMP_W'(cfg.multi_click_ms);

	always_comb begin
		sp_d     = sp;
		sr_d     = sr;
		hold_d   = hold_time_q;
		acc_d    = press_accepted_q;
		long_d   = long_active_q;
		clicks_d = clicks_q;
		ev_d     = EV_NONE;
		if (now_p) begin
			if (!before_p) begin
				sp_d   = '0;
				sr_d   = '0;
				acc_d  = 1'b0;
				long_d = 1'b0;
			end else if (!press_accepted_q && deb_ok) begin
				acc_d    = 1'b1;
				clicks_d = clicks_q + 8'd1;
				ev_d     = EV_PRESSED;
			end else if (press_accepted_q && clicks_q == 8'd1) begin
				if (!long_active_q && long_ok) begin
					hold_d = sp;
					long_d = 1'b1;
					sr_d   = '0;
					ev_d   = EV_LONG_FIRST;
				end else if (long_active_q && rep_ok) begin
					hold_d = sp;
					sr_d   = '0;
					ev_d   = EV_LONG_REPEAT;
				end
			end
		end else if (press_accepted_q) begin
			if (before_p) begin
				hold_d = sp;
				if (clicks_q == 8'd1 && long_active_q) begin
					ev_d     = EV_LONG_FINISH;
					long_d   = 1'b0;
					acc_d    = 1'b0;
					clicks_d = '0;
				end else begin
					ev_d = EV_RELEASED;
				end
			end else if (clicks_q != 8'd0 && multi_ok) begin
				ev_d     = EV_CLICK_FINISH;
				acc_d    = 1'b0;
				clicks_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q     <= 1'b1;
			since_press_q    <= '0;
			since_repeat_q   <= '0;
			press_accepted_q <= 1'b0;
			long_active_q    <= 1'b0;
			clicks_q         <= '0;
			hold_time_q      <= '0;
		end else if (en) begin
			last_level_q     <= pin_level;
			since_press_q    <= sp_d;
			since_repeat_q   <= sr_d;
			press_accepted_q <= acc_d;
			long_active_q    <= long_d;
			clicks_q         <= clicks_d;
			hold_time_q      <= hold_d;
		end
	end

	assign res.event_res   = ev_d;
	assign res.click_count = clicks_d;
	assign res.held_ms     = 16'(hold_d);
	assign res.is_pressed  = now_p;

	// a finished sequence leaves no accepted press and no clicks
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && (ev_d == EV_CLICK_FINISH || ev_d == EV_LONG_FINISH))
		|=> (!press_accepted_q && clicks_q == 8'd0))
		else $error("sequence finish left click state behind");

	// the repeat timer restarts at or after the press timer
	a_timer_order: assert property (@(posedge clk) disable iff (!arst_n)
		since_repeat_q <= since_press_q)
		else $error("repeat timer ahead of press timer");

	a_pressed_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ev_d == EV_PRESSED) |=> press_accepted_q)
		else $error("pressed event without accepted press");

endmodule

// ===== rtl/core/button_click_longpress_detector_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_longpress_detector_unit
// Debounced button decoder with multi-click counting and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one poll per transfer: the raw pin level and the milliseconds
//   since the previous poll. m_* gives exactly one result per poll: event
//   code, click count, held time and the raw pressed flag.
//   A poll passes from the input transfer into the input register, then through
//   the decode logic into the output register, which drives m_tvalid.
//   Throughput is one poll per cycle while the receiver does not stall; the state
//   update is a combinational compare-and-add path between the two registers.
//   When the receiver stalls, the result waits in the output register and one
//   more poll is held in the input register; s_tready drops only when both
//   are full. Nothing is lost or repeated.
//   Reset clears the timers, click state and held time, loads the default
//   thresholds (20, 1000, 500, 400 ms, active low) and empties both registers.
//   The user must write the APB port only while no poll is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_click_longpress_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [0] pin_level, [8:1] elapsed_ms, [15:9] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] event_res, [10:3] click_count, [26:11] held_ms, [27] is_pressed, [31:28] zero
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bcl_pkg::*;

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic       pin_s1;
	logic [7:0] elapsed_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       adv;

	bcl_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// poll in s1 moves on when the output register is free or being drained
	assign adv      = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_s1     <= s_tdata[0];
			elapsed_s1 <= s_tdata[8:1];
		end
	end

	bcl_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.pin_level  (pin_s1),
		.elapsed_ms (elapsed_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.is_pressed, res_s2.held_ms,
		res_s2.click_count, res_s2.event_res};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives button polls into the click / long-press decoder and checks every
// result against an in-bench decoder model: directed press and release
// sequences, timer saturation, click counter wrap, then random episodes over
// several threshold settings with random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import bcl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  clicks;
		logic [15:0] held;
		logic        pressed;
	} poll_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // [0] pin_level, [8:1] elapsed_ms, [15:9] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [2:0] event_res, [10:3] click_count, [26:11] held_ms, [27] is_pressed
	logic [31:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// decoder model: thresholds and state
	logic        cfg_active_low;
	logic [7:0]  cfg_debounce;
	logic [15:0] cfg_long;
	logic [15:0] cfg_repeat;
	logic [15:0] cfg_window;
	logic        prev_level;
	logic [15:0] press_timer;
	logic [15:0] repeat_timer;
	logic        accepted;
	logic        long_on;
	logic [7:0]  click_cnt;
	logic [15:0] held_time;

	poll_result_t expected_q[$];
	int errors  = 0;
	int cycles  = 0;
	int rx_hold = 0;
	bit gaps_on = 1'b1;

	button_click_longpress_detector_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] clip_add(input logic [15:0] t, input logic [7:0] ms);
		logic [16:0] sum;
		sum = {1'b0, t} + {9'd0, ms};
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	function automatic void reset_model();
		cfg_active_low = RST_ACTIVE_LOW;
		cfg_debounce   = RST_DEBOUNCE_TIME;
		cfg_long       = RST_LONG_PRESS_MS;
		cfg_repeat     = RST_REPEAT_MS;
		cfg_window     = RST_MULTI_CLICK_MS;
		prev_level     = 1'b1;
		press_timer    = '0;
		repeat_timer   = '0;
		accepted       = 1'b0;
		long_on        = 1'b0;
		click_cnt      = '0;
		held_time      = '0;
	endfunction

	// advance the decoder by one poll and return the result it gives
	function automatic poll_result_t decode_poll(input logic pin, input logic [7:0] ms);
		poll_result_t r;
		logic pl, now_p, was_p;
		pl    = ~cfg_active_low;
		now_p = (pin == pl);
		was_p = (prev_level == pl);
		r.ev  = EV_NONE;
		press_timer  = clip_add(press_timer, ms);
		repeat_timer = clip_add(repeat_timer, ms);
		prev_level   = pin;
		if (now_p) begin
			if (!was_p) begin
				press_timer  = '0;
				repeat_timer = '0;
				accepted     = 1'b0;
				long_on      = 1'b0;
			end else if (!accepted && press_timer >= {8'd0, cfg_debounce}) begin
				accepted  = 1'b1;
				click_cnt = click_cnt + 8'd1;
				r.ev      = EV_PRESSED;
			end else if (accepted && click_cnt == 8'd1) begin
				if (!long_on && press_timer >= cfg_long) begin
					held_time    = press_timer;
					long_on      = 1'b1;
					repeat_timer = '0;
					r.ev         = EV_LONG_FIRST;
				end else if (long_on && repeat_timer >= cfg_repeat) begin
					held_time    = press_timer;
					repeat_timer = '0;
					r.ev         = EV_LONG_REPEAT;
				end
			end
		end else if (accepted) begin
			if (was_p) begin
				held_time = press_timer;
				if (click_cnt == 8'd1 && long_on) begin
					r.ev      = EV_LONG_FINISH;
					long_on   = 1'b0;
					accepted  = 1'b0;
					click_cnt = '0;
				end else begin
					r.ev = EV_RELEASED;
				end
			end else if (click_cnt != 8'd0 && press_timer >= cfg_window) begin
				r.ev      = EV_CLICK_FINISH;
				accepted  = 1'b0;
				click_cnt = '0;
			end
		end
		r.clicks  = click_cnt;
		r.held    = held_time;
		r.pressed = now_p;
		return r;
	endfunction

	// one poll transfer; valid stays high into the next poll when no gap is drawn
	task automatic send_poll(input logic pin, input logic [7:0] ms);
		int gap;
		gap = gaps_on ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, ms, pin};
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(decode_poll(pin, ms));
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] mask;
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ACTIVE_LOW: begin
				mask = 32'h1;
				cfg_active_low = val[0];
			end
			REG_DEBOUNCE_TIME: begin
				mask = 32'hFF;
				cfg_debounce = val[7:0];
			end
			REG_LONG_PRESS_MS: begin
				mask = 32'hFFFF;
				cfg_long = val[15:0];
			end
			REG_REPEAT_MS: begin
				mask = 32'hFFFF;
				cfg_repeat = val[15:0];
			end
			default: begin
				mask = 32'hFFFF;
				cfg_window = val[15:0];
			end
		endcase
		// read back through a second setup and access
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== (val & mask)) begin
			$display("%0t register %0d: expected %0h, actual %0h", $time, idx, val & mask, rd);
			errors++;
		end
	endtask

	task automatic apply_config(input logic al, input logic [7:0] db, input logic [15:0] lp,
			input logic [15:0] rp, input logic [15:0] mc);
		write_reg(REG_ACTIVE_LOW, {31'd0, al});
		write_reg(REG_DEBOUNCE_TIME, {24'd0, db});
		write_reg(REG_LONG_PRESS_MS, {16'd0, lp});
		write_reg(REG_REPEAT_MS, {16'd0, rp});
		write_reg(REG_MULTI_CLICK_MS, {16'd0, mc});
	endtask

	function automatic logic [7:0] poll_ms();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 40));
	endfunction

	// press / release episodes of random length, with single-poll glitches between
	task automatic run_episodes(input int n);
		int sent, hold_n, rel_n;
		logic pl;
		sent = 0;
		while (sent < n) begin
			pl = ~cfg_active_low;
			if ($urandom_range(0, 4) == 0) begin
				send_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				sent++;
			end else begin
				hold_n = $urandom_range(1, 16);
				rel_n  = $urandom_range(1, 10);
				repeat (hold_n) send_poll(pl, poll_ms());
				repeat (rel_n) send_poll(~pl, poll_ms());
				sent += hold_n + rel_n;
			end
		end
	endtask

	// reset thresholds, active low: low pin level is pressed
	task automatic test_directed();
		send_poll(1'b1, 8'd0);
		send_poll(1'b1, 8'd255);
		// debounce reached on the third poll of the press
		send_poll(1'b0, 8'd5);
		send_poll(1'b0, 8'd19);
		send_poll(1'b0, 8'd1);
		// long first, then one repeat, then long finish on release
		repeat (6) send_poll(1'b0, 8'd255);
		send_poll(1'b1, 8'd3);
		// release before debounce gives nothing
		send_poll(1'b0, 8'd0);
		send_poll(1'b0, 8'd10);
		send_poll(1'b1, 8'd0);
		// double click, then the window runs out
		send_poll(1'b0, 8'd0);
		send_poll(1'b0, 8'd20);
		send_poll(1'b1, 8'd0);
		send_poll(1'b0, 8'd0);
		send_poll(1'b0, 8'd30);
		send_poll(1'b1, 8'd0);
		send_poll(1'b1, 8'd255);
		send_poll(1'b1, 8'd255);
	endtask

	task automatic test_timer_saturation();
		settle();
		apply_config(1'b1, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_poll(1'b0, 8'd0);
		send_poll(1'b0, 8'd255);
		// press timer pins at all ones, long first fires there
		repeat (265) send_poll(1'b0, 8'($urandom_range(250, 255)));
		send_poll(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_click_wrap();
		settle();
		apply_config(1'b1, 8'd0, 16'hFFFF, 16'hFFFF, 16'd0);
		repeat (256) begin
			send_poll(1'b0, poll_ms());
			send_poll(1'b0, poll_ms());
			send_poll(1'b1, poll_ms());
		end
		// count is back at zero, so the sequence cannot finish
		repeat (3) send_poll(1'b1, 8'd255);
		send_poll(1'b0, 8'd7);
		send_poll(1'b0, 8'd0);
		send_poll(1'b1, 8'd0);
		send_poll(1'b1, 8'd0);
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 4; p++) begin
			settle();
			if (p == 0)
				apply_config(1'b1, 8'd0, 16'd0, 16'd0, 16'd0);
			else
				apply_config(p[0] ? 1'b0 : 1'b1, 8'($urandom_range(0, 50)),
					16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)),
					16'($urandom_range(0, 300)));
			gaps_on = (p != 1);
			// output held off while polls keep coming, input must stall
			if (p == 1)
				rx_hold = 300;
			run_episodes(70);
		end
		gaps_on = 1'b1;
	endtask

	initial begin : result_check
		poll_result_t want;
		event_t       got_ev;
		int           stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got_ev = event_t'(m_tdata[2:0]);
				if (expected_q.size() == 0) begin
					$display("%0t result with nothing expected: actual %0h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got_ev !== want.ev) begin
						$display("%0t event: expected %0d, actual %0d", $time, want.ev, got_ev);
						errors++;
					end
					if (m_tdata[10:3] !== want.clicks) begin
						$display("%0t click_count: expected %0d, actual %0d",
							$time, want.clicks, m_tdata[10:3]);
						errors++;
					end
					if (m_tdata[26:11] !== want.held) begin
						$display("%0t held_ms: expected %0d, actual %0d",
							$time, want.held, m_tdata[26:11]);
						errors++;
					end
					if (m_tdata[27] !== want.pressed) begin
						$display("%0t is_pressed: expected %0b, actual %0b",
							$time, want.pressed, m_tdata[27]);
						errors++;
					end
				end
				stall = gaps_on ? $urandom_range(0, 17) : 0;
			end
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_timer_saturation();
		test_click_wrap();
		test_random_phases();
		settle();
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
